[design/ppe_pkg.sv]
// shared types and constants of the particle pool engine
package ppe_pkg;

  localparam int unsigned SLOT_W      = 5;
  localparam int unsigned LIFE_W      = 17;
  localparam int unsigned DT_W        = 24;
  localparam int unsigned PROD_W      = 57;
  localparam int unsigned MAX_RESULTS = 32;
  localparam logic [LIFE_W-1:0] LIFE_ONE = 17'd65536;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_TICK = 2'd1,
    OP_DRAW = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_ADDED  = 2'd0,
    KIND_TICKED = 2'd1,
    KIND_SPRITE = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ASCAN,
    ST_AEMIT,
    ST_TSCAN,
    ST_TMUL,
    ST_TWB,
    ST_TEMIT,
    ST_DSCAN,
    ST_DOUT,
    ST_DEMPTY
  } state_t;

  typedef struct packed {
    logic [LIFE_W-1:0] life;
    logic [31:0]       px;
    logic [31:0]       py;
    logic [31:0]       vx;
    logic [31:0]       vy;
    logic [31:0]       tint;
    logic [31:0]       extent;
  } word_t;

  typedef struct packed {
    logic [1:0]      operation;
    logic [31:0]     pos_x;
    logic [31:0]     pos_y;
    logic [31:0]     vel_x;
    logic [31:0]     vel_y;
    logic [31:0]     colour;
    logic [31:0]     size;
    logic [DT_W-1:0] delta_time;
  } item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       x;
    logic [31:0]       y;
    logic [31:0]       size;
    logic [31:0]       colour;
    logic [31:0]       texture;
    logic              last;
  } result_t;

  // position plus floor(product / 2^16), saturated to 32 bits
  function automatic logic [31:0] advance(input logic [31:0] pos,
                                          input logic [PROD_W-1:0] prod);
    logic signed [40:0] step;
    logic signed [41:0] sum;
    logic [31:0]        res;
    step = $signed(prod[PROD_W-1:16]);
    sum  = $signed({{10{pos[31]}}, pos}) + $signed({step[40], step});
    if (sum > 42'sd2147483647) begin
      res = 32'h7fff_ffff;
    end else if (sum < -42'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = sum[31:0];
    end
    return res;
  endfunction

endpackage

[design/ppe_in_if.sv]
// input channel interface
interface ppe_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic [31:0]        colour;
  logic [31:0]        size;
  logic [23:0]        delta_time;

  modport source (output valid, operation, pos_x, pos_y, vel_x, vel_y, colour, size,
                  delta_time, input ready);
  modport sink (input valid, operation, pos_x, pos_y, vel_x, vel_y, colour, size,
                delta_time, output ready);
endinterface

[design/ppe_out_if.sv]
// result channel interface
interface ppe_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [4:0]         slot;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic [31:0]        out_size;
  logic [31:0]        out_colour;
  logic [31:0]        texture;
  logic               last;

  modport source (output valid, kind, slot, out_x, out_y, out_size, out_colour, texture,
                  last, input ready);
  modport sink (input valid, kind, slot, out_x, out_y, out_size, out_colour, texture,
                last, output ready);
endinterface

[design/particle_pool_engine_core.sv]
// particle pool engine top level
// One operation is worked at a time; the particle records sit in one memory with one read
// and one write port, walked one slot at a time, and the live flags sit in a register. An
// add probes slots from the remembered free index. A tick reads, multiplies and writes
// back each live slot. A draw scans the slots and emits one sprite per live slot, stopping
// at the last sprite or at MAX_RESULTS sprites; a draw that finds nothing live emits one
// empty result. A step that loads the output register waits while it stays full. A new
// operation is taken as soon as the previous one has loaded its final result into the
// output register.
module particle_pool_engine_core #(
  parameter int unsigned PARTICLES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  ppe_in_if.sink      in_ch,
  ppe_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ppe_pkg::*;

  localparam int unsigned IW = $clog2(PARTICLES);
  localparam int unsigned CW = $clog2(PARTICLES + 1);
  localparam int unsigned NW = $clog2(MAX_RESULTS + 1);

  state_t               state_r, state_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [NW-1:0]        count_r, count_nxt;
  logic [IW-1:0]        nf_r, nf_nxt;
  logic [PARTICLES-1:0] alive_r, alive_nxt;
  logic                 found_r, found_nxt;
  item_t                item_r, item_nxt;
  logic [31:0]          dec_r, dec_nxt;
  logic [PROD_W-1:0]    prodx_r, prodx_nxt, prody_r, prody_nxt;
  result_t              out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DT_W-1:0]      decay_r;
  logic [31:0]          tex_r;

  logic                 ram_we, ram_re;
  logic [IW-1:0]        ram_waddr;
  word_t                ram_wdata, rd;
  logic [IW-1:0]        slot_i;
  logic                 out_free;
  logic [47:0]          dec_full;
  logic [LIFE_W-1:0]    life_new;
  logic                 more_live;

  ppe_ram #(.WIDTH($bits(word_t)), .DEPTH(PARTICLES)) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re     (ram_re),
    .raddr  (slot_i),
    .rdata_r(rd)
  );

  assign slot_i     = idx_r[IW-1:0];
  assign out_free   = !out_valid_r || out_ch.ready;
  assign dec_full   = decay_r * in_ch.delta_time;
  assign life_new   = (dec_r >= {15'd0, rd.life}) ? '0 : rd.life - dec_r[LIFE_W-1:0];
  assign more_live  = |((alive_r >> slot_i) >> 1);

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? tex_r : {8'd0, decay_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= 24'd65536;
      tex_r   <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2]) begin
        tex_r <= cfg_pwdata;
      end else begin
        decay_r <= cfg_pwdata[DT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nf_r        <= '0;
      alive_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nf_r        <= nf_nxt;
      alive_r     <= alive_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
    count_r <= count_nxt;
    found_r <= found_nxt;
    item_r  <= item_nxt;
    dec_r   <= dec_nxt;
    prodx_r <= prodx_nxt;
    prody_r <= prody_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    count_nxt     = count_r;
    nf_nxt        = nf_r;
    alive_nxt     = alive_r;
    found_nxt     = found_r;
    item_nxt      = item_r;
    dec_nxt       = dec_r;
    prodx_nxt     = prodx_r;
    prody_nxt     = prody_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = slot_i;
    ram_wdata     = rd;
    in_ch.ready   = (state_r == ST_IDLE);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          item_nxt.operation  = in_ch.operation;
          item_nxt.pos_x      = in_ch.pos_x;
          item_nxt.pos_y      = in_ch.pos_y;
          item_nxt.vel_x      = in_ch.vel_x;
          item_nxt.vel_y      = in_ch.vel_y;
          item_nxt.colour     = in_ch.colour;
          item_nxt.size       = in_ch.size;
          item_nxt.delta_time = in_ch.delta_time;
          dec_nxt             = dec_full[47:16];
          cnt_nxt             = '0;
          count_nxt           = '0;
          idx_nxt             = '0;
          case (in_ch.operation)
            OP_ADD: begin
              idx_nxt   = CW'(nf_r);
              state_nxt = ST_ASCAN;
            end
            OP_TICK: state_nxt = ST_TSCAN;
            OP_DRAW: state_nxt = ST_DSCAN;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ASCAN: begin
        if (!alive_r[slot_i]) begin
          found_nxt = 1'b1;
          state_nxt = ST_AEMIT;
        end else if (cnt_r == CW'(PARTICLES - 1)) begin
          found_nxt = 1'b0;
          idx_nxt   = '0;
          state_nxt = ST_AEMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          idx_nxt = (idx_r == CW'(PARTICLES - 1)) ? '0 : idx_r + 1'b1;
        end
      end
      ST_AEMIT: begin
        if (out_free) begin
          ram_we            = 1'b1;
          ram_wdata.life    = LIFE_ONE;
          ram_wdata.px      = item_r.pos_x;
          ram_wdata.py      = item_r.pos_y;
          ram_wdata.vx      = item_r.vel_x;
          ram_wdata.vy      = item_r.vel_y;
          ram_wdata.tint    = item_r.colour;
          ram_wdata.extent  = item_r.size;
          alive_nxt[slot_i] = 1'b1;
          if (found_r) begin
            nf_nxt = slot_i;
          end
          out_nxt       = '0;
          out_nxt.kind  = KIND_ADDED;
          out_nxt.slot  = SLOT_W'(slot_i);
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_TSCAN: begin
        if (idx_r == CW'(PARTICLES)) begin
          state_nxt = ST_TEMIT;
        end else if (alive_r[slot_i]) begin
          ram_re    = 1'b1;
          state_nxt = ST_TMUL;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_TMUL: begin
        prodx_nxt = $signed(rd.vx) * $signed({1'b0, item_r.delta_time});
        prody_nxt = $signed(rd.vy) * $signed({1'b0, item_r.delta_time});
        state_nxt = ST_TWB;
      end
      ST_TWB: begin
        ram_we            = 1'b1;
        ram_wdata.px      = advance(rd.px, prodx_r);
        ram_wdata.py      = advance(rd.py, prody_r);
        ram_wdata.life    = life_new;
        alive_nxt[slot_i] = (life_new != '0);
        idx_nxt           = idx_r + 1'b1;
        state_nxt         = ST_TSCAN;
      end
      ST_TEMIT: begin
        if (out_free) begin
          out_nxt       = '0;
          out_nxt.kind  = KIND_TICKED;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DSCAN: begin
        if (idx_r == CW'(PARTICLES)) begin
          state_nxt = ST_DEMPTY;
        end else if (alive_r[slot_i]) begin
          ram_re    = 1'b1;
          state_nxt = ST_DOUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DOUT: begin
        if (out_free) begin
          out_nxt.kind    = KIND_SPRITE;
          out_nxt.slot    = SLOT_W'(slot_i);
          out_nxt.x       = rd.px;
          out_nxt.y       = rd.py;
          out_nxt.size    = rd.extent;
          out_nxt.colour  = rd.tint;
          out_nxt.texture = tex_r;
          out_nxt.last    = (count_r == NW'(MAX_RESULTS - 1)) || !more_live;
          out_valid_nxt   = 1'b1;
          count_nxt       = count_r + 1'b1;
          idx_nxt         = idx_r + 1'b1;
          state_nxt       = out_nxt.last ? ST_IDLE : ST_DSCAN;
        end
      end
      ST_DEMPTY: begin
        if (out_free) begin
          out_nxt       = '0;
          out_nxt.kind  = KIND_EMPTY;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_r.kind;
  assign out_ch.slot       = out_r.slot;
  assign out_ch.out_x      = out_r.x;
  assign out_ch.out_y      = out_r.y;
  assign out_ch.out_size   = out_r.size;
  assign out_ch.out_colour = out_r.colour;
  assign out_ch.texture    = out_r.texture;
  assign out_ch.last       = out_r.last;
endmodule

[design/ppe_ram.sv]
// generic single-port-write ram with registered read
module ppe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end
endmodule
